// ===== rtl/cfe_pkg.sv =====
// Shared types, constants and helper functions of the cuckoo filter engine.
// No dependencies; every other file of the engine but cfe_ram imports this package.
package cfe_pkg;

    localparam int NUM_BUCKETS      = 1024;
    localparam int SLOTS_PER_BUCKET = 4;
    localparam int BUCKET_W         = $clog2(NUM_BUCKETS);
    localparam int SLOT_W           = $clog2(SLOTS_PER_BUCKET);
    localparam int FP_W             = 31;
    localparam int ENTRY_W          = FP_W + 1;
    localparam int ROW_W            = SLOTS_PER_BUCKET * ENTRY_W;
    localparam int CNT_W            = 13;
    localparam int DUP_W            = $clog2(2 * SLOTS_PER_BUCKET + 1);
    localparam int KICK_LIMIT_DEF   = 500;
    localparam int QUEUE_DEPTH      = 2;
    localparam logic [31:0] LFSR_MASK = 32'h8020_0003;
    localparam logic [31:0] LFSR_SEED = 32'h0000_0001;

    localparam logic [4:0]       FP_BITS_RST = 5'd8;
    localparam logic [4:0]       LEVEL_RST   = 5'd0;
    localparam logic [CNT_W-1:0] CAP_RST     = 13'd3891;

    localparam logic [1:0] CFG_FP_BITS = 2'd0;
    localparam logic [1:0] CFG_LEVEL   = 2'd1;
    localparam logic [1:0] CFG_CAP     = 2'd2;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_LOOKUP = 2'd1,
        MODE_REMOVE = 2'd2,
        MODE_VICTIM = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        ST_STORED      = 4'd0,
        ST_DUP_LIMIT   = 4'd1,
        ST_OVER_CAP    = 4'd2,
        ST_EVICTED     = 4'd3,
        ST_FOUND       = 4'd4,
        ST_ABSENT      = 4'd5,
        ST_REMOVED     = 4'd6,
        ST_NOT_PRESENT = 4'd7,
        ST_VICTIM_FULL = 4'd8
    } status_t;

    typedef enum logic [3:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_RD1,
        BK_RD2,
        BK_EVAL,
        BK_KICK,
        BK_KRD,
        BK_KEV,
        BK_DONE
    } back_state_t;

    typedef struct packed {
        logic [4:0]       fp_bits;
        logic [4:0]       level;
        logic [CNT_W-1:0] cap;
    } cfg_t;

    typedef struct packed {
        mode_t               mode;
        logic [FP_W-1:0]     fp;
        logic [FP_W-1:0]     key;
        logic [FP_W-1:0]     saved;
        logic [BUCKET_W-1:0] b1;
        logic [BUCKET_W-1:0] b2;
    } item_t;

    // Bits kept of a fingerprint once the low level bits are dropped.
    function automatic logic [FP_W-1:0] store_mask(input logic [4:0] fb,
                                                   input logic [4:0] lvl);
        logic [4:0]  fbe;
        logic [4:0]  w;
        logic [31:0] m;
        fbe = (fb == 5'd0) ? 5'd1 : fb;
        w   = (fbe > lvl) ? (fbe - lvl) : 5'd0;
        m   = (32'd1 << w) - 32'd1;
        return m[FP_W-1:0];
    endfunction

    function automatic logic [ROW_W-1:0] set_slot(input logic [ROW_W-1:0]  row,
                                                  input logic [SLOT_W-1:0] s,
                                                  input logic [FP_W-1:0]   fp,
                                                  input logic              occ);
        logic [ROW_W-1:0] r;
        r = row;
        for (int i = 0; i < SLOTS_PER_BUCKET; i++) begin
            if (SLOT_W'(i) == s) begin
                r[i*ENTRY_W +: ENTRY_W] = {occ, fp};
            end
        end
        return r;
    endfunction

endpackage

// ===== rtl/cfe_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module cfe_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/cfe_front.sv =====
// Front end: accepts request items and works out fingerprint, key and buckets.
// Depends on cfe_pkg.
module cfe_front
    import cfe_pkg::*;
(
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [111:0] s_tdata,
    input  logic [2:0]   s_tuser,
    input  cfg_t         cfg,
    input  logic         clearing,
    input  logic         q_full,
    output logic         push,
    output item_t        item
);

    logic [63:0]       ih;
    logic [FP_W-1:0]   given;
    logic [BUCKET_W-1:0] vb;
    logic              use_given;
    mode_t             mode;
    logic [4:0]        fbe;
    logic [31:0]       fp_mask;
    logic [FP_W-1:0]   fp;
    logic [FP_W-1:0]   lvl_mask;

    assign ih        = s_tdata[63:0];
    assign given     = s_tdata[94:64];
    assign vb        = s_tdata[104:95];
    assign mode      = mode_t'(s_tuser[1:0]);
    assign use_given = s_tuser[2];

    always_comb begin
        fbe      = (cfg.fp_bits == 5'd0) ? 5'd1 : cfg.fp_bits;
        fp_mask  = (32'd1 << fbe) - 32'd1;
        // victim inserts always carry their own fingerprint
        fp       = (use_given || mode == MODE_VICTIM) ? given : (ih[FP_W-1:0] & fp_mask[FP_W-1:0]);
        lvl_mask = (FP_W'(1) << cfg.level) - FP_W'(1);
        item.mode  = mode;
        item.fp    = fp;
        item.key   = fp >> cfg.level;
        item.saved = fp & lvl_mask;
        item.b1    = (mode == MODE_VICTIM) ? vb : ih[BUCKET_W-1:0];
        item.b2    = ih[BUCKET_W-1:0] ^ fp[BUCKET_W-1:0];
    end

    // hold off while the table sweep runs or the queue is full
    assign s_tready = !clearing && !q_full;
    assign push     = s_tvalid && s_tready;

endmodule

// ===== rtl/cfe_queue.sv =====
// Short item queue between the front end and the table engine.
// Depends on cfe_pkg.
module cfe_queue
    import cfe_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  item_t item_in,
    output logic  full,
    input  logic  pop,
    output item_t item_out,
    output logic  empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    item_t              buf_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_reg, wr_next;
    logic [PTR_W-1:0]   rd_reg, rd_next;
    logic [PTR_W:0]     cnt_reg, cnt_next;

    always_comb begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push) begin
            wr_next = (wr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (pop) begin
            rd_next = (rd_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
        if (push) begin
            buf_reg[wr_reg] <= item_in;
        end
    end

    assign full     = (cnt_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign item_out = buf_reg[rd_reg];

endmodule

// ===== rtl/cfe_back.sv =====
// Table engine: clears the bucket memory, then carries out queued requests
// (lookup, remove, insert with kick chain, victim insert). Depends on cfe_pkg, cfe_ram.
module cfe_back
    import cfe_pkg::*;
#(
    parameter int KICK_LIMIT = KICK_LIMIT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  logic        q_empty,
    input  item_t       q_item,
    output logic        q_pop,
    output logic        clearing,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,
    output logic [0:0]  m_tuser
);

    localparam int KW = $clog2(KICK_LIMIT + 1);

    back_state_t         state_reg, state_next;
    item_t               item_reg, item_next;
    logic [ROW_W-1:0]    row1_reg, row1_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [BUCKET_W-1:0] cur_reg, cur_next;
    logic [BUCKET_W-1:0] from_reg, from_next;
    logic [FP_W-1:0]     fp_reg, fp_next;
    logic [FP_W-1:0]     key_reg, key_next;
    logic [KW-1:0]       kick_reg, kick_next;
    logic [31:0]         lfsr_reg, lfsr_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                accepting_reg, accepting_next;
    logic [BUCKET_W-1:0] clr_reg, clr_next;
    status_t             status_reg, status_next;
    logic [FP_W-1:0]     vfp_reg, vfp_next;
    logic [BUCKET_W-1:0] vidx_reg, vidx_next;
    logic                mv_reg, mv_next;
    logic [63:0]         mdata_reg, mdata_next;
    logic                mfull_reg, mfull_next;

    logic                ram_we, ram_re;
    logic [BUCKET_W-1:0] ram_waddr, ram_raddr;
    logic [ROW_W-1:0]    ram_wdata, ram_rdata;

    logic [SLOTS_PER_BUCKET-1:0] hit1, hit2, occ1, occk;
    logic [DUP_W-1:0]    dup_cnt;
    logic                free1_ok, freek_ok, rm_ok, rm_in_b1;
    logic [SLOT_W-1:0]   free1_idx, freek_idx, rm_idx, pick;
    logic [FP_W-1:0]     smask, old_fp, kick_fp;
    logic [61:0]         shifted;
    logic [31:0]         lfsr_adv;
    logic                out_free;

    cfe_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_BUCKETS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // slot matches and free-slot searches over the buckets in hand
    always_comb begin
        for (int s = 0; s < SLOTS_PER_BUCKET; s++) begin
            occ1[s] = row1_reg[s*ENTRY_W + FP_W];
            occk[s] = ram_rdata[s*ENTRY_W + FP_W];
            hit1[s] = occ1[s] && (row1_reg[s*ENTRY_W +: FP_W] == item_reg.key);
            hit2[s] = occk[s] && (ram_rdata[s*ENTRY_W +: FP_W] == item_reg.key);
        end
        dup_cnt   = DUP_W'($countones({hit1, hit2}));
        free1_ok  = 1'b0;
        free1_idx = '0;
        freek_ok  = 1'b0;
        freek_idx = '0;
        rm_ok     = 1'b0;
        rm_in_b1  = 1'b0;
        rm_idx    = '0;
        for (int s = SLOTS_PER_BUCKET - 1; s >= 0; s--) begin
            if (!occ1[s]) begin
                free1_ok  = 1'b1;
                free1_idx = SLOT_W'(s);
            end
            if (!occk[s]) begin
                freek_ok  = 1'b1;
                freek_idx = SLOT_W'(s);
            end
            if (hit1[s] || hit2[s]) begin
                rm_ok    = 1'b1;
                rm_in_b1 = hit1[s];
                rm_idx   = SLOT_W'(s);
            end
        end
        smask    = store_mask(cfg.fp_bits, cfg.level);
        lfsr_adv = (lfsr_reg >> 1) ^ (lfsr_reg[0] ? LFSR_MASK : 32'd0);
        pick     = lfsr_adv[SLOT_W-1:0];
        old_fp   = row_reg[int'(pick)*ENTRY_W +: FP_W];
        shifted  = {31'd0, old_fp} << cfg.level;
        kick_fp  = shifted[FP_W-1:0] | item_reg.saved;
        out_free = !mv_reg || m_tready;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_CLEAR: begin
                if (clr_reg == BUCKET_W'(NUM_BUCKETS - 1)) state_next = BK_IDLE;
            end
            BK_IDLE: begin
                if (!q_empty) state_next = BK_RD1;
            end
            BK_RD1: state_next = BK_RD2;
            BK_RD2: state_next = BK_EVAL;
            BK_EVAL: begin
                if (item_reg.mode == MODE_INSERT && count_reg < cfg.cap &&
                    dup_cnt < DUP_W'(SLOTS_PER_BUCKET) && !free1_ok) begin
                    state_next = BK_KICK;
                end else begin
                    state_next = BK_DONE;
                end
            end
            BK_KICK: state_next = BK_KRD;
            BK_KRD:  state_next = BK_KEV;
            BK_KEV: begin
                if (freek_ok || kick_reg == KW'(KICK_LIMIT)) begin
                    state_next = BK_DONE;
                end else begin
                    state_next = BK_KICK;
                end
            end
            BK_DONE: begin
                if (out_free) state_next = BK_IDLE;
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        item_next      = item_reg;
        row1_next      = row1_reg;
        row_next       = row_reg;
        cur_next       = cur_reg;
        from_next      = from_reg;
        fp_next        = fp_reg;
        key_next       = key_reg;
        kick_next      = kick_reg;
        lfsr_next      = lfsr_reg;
        count_next     = count_reg;
        accepting_next = accepting_reg;
        clr_next       = clr_reg;
        status_next    = status_reg;
        vfp_next       = vfp_reg;
        vidx_next      = vidx_reg;
        mdata_next     = mdata_reg;
        mfull_next     = mfull_reg;
        mv_next        = mv_reg && !m_tready;
        ram_we         = 1'b0;
        ram_waddr      = item_reg.b1;
        ram_wdata      = row1_reg;
        ram_re         = 1'b0;
        ram_raddr      = item_reg.b1;
        q_pop          = 1'b0;
        clearing       = 1'b0;
        case (state_reg)
            BK_CLEAR: begin
                clearing  = 1'b1;
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + 1'b1;
            end
            BK_IDLE: begin
                if (!q_empty) begin
                    q_pop     = 1'b1;
                    item_next = q_item;
                    vfp_next  = '0;
                    vidx_next = '0;
                end
            end
            BK_RD1: begin
                ram_re    = 1'b1;
                ram_raddr = item_reg.b1;
            end
            BK_RD2: begin
                ram_re    = 1'b1;
                ram_raddr = item_reg.b2;
                row1_next = ram_rdata;
            end
            BK_EVAL: begin
                case (item_reg.mode)
                    MODE_LOOKUP: begin
                        status_next = (|(hit1 | hit2)) ? ST_FOUND : ST_ABSENT;
                    end
                    MODE_REMOVE: begin
                        status_next = ST_NOT_PRESENT;
                        if (rm_ok) begin
                            status_next = ST_REMOVED;
                            ram_we      = 1'b1;
                            if (rm_in_b1) begin
                                ram_waddr = item_reg.b1;
                                ram_wdata = set_slot(row1_reg, rm_idx,
                                    row1_reg[int'(rm_idx)*ENTRY_W +: FP_W], 1'b0);
                            end else begin
                                ram_waddr = item_reg.b2;
                                ram_wdata = set_slot(ram_rdata, rm_idx,
                                    ram_rdata[int'(rm_idx)*ENTRY_W +: FP_W], 1'b0);
                            end
                            if (count_reg != '0) count_next = count_reg - 1'b1;
                        end
                    end
                    MODE_VICTIM: begin
                        if (free1_ok) begin
                            status_next = ST_STORED;
                            ram_we      = 1'b1;
                            ram_waddr   = item_reg.b1;
                            ram_wdata   = set_slot(row1_reg, free1_idx,
                                                   item_reg.key & smask, 1'b1);
                            count_next  = count_reg + 1'b1;
                        end else begin
                            status_next = ST_VICTIM_FULL;
                        end
                    end
                    MODE_INSERT: begin
                        if (count_reg >= cfg.cap) begin
                            status_next = ST_OVER_CAP;
                        end else if (dup_cnt >= DUP_W'(SLOTS_PER_BUCKET)) begin
                            status_next = ST_DUP_LIMIT;
                        end else if (free1_ok) begin
                            status_next = ST_STORED;
                            ram_we      = 1'b1;
                            ram_waddr   = item_reg.b1;
                            ram_wdata   = set_slot(row1_reg, free1_idx,
                                                   item_reg.key & smask, 1'b1);
                            count_next  = count_reg + 1'b1;
                        end else begin
                            // first bucket full: start the kick chain there
                            row_next  = row1_reg;
                            cur_next  = item_reg.b1;
                            from_next = item_reg.b1;
                            fp_next   = item_reg.fp;
                            key_next  = item_reg.key;
                            kick_next = '0;
                        end
                    end
                    default: status_next = ST_ABSENT;
                endcase
            end
            BK_KICK: begin
                // swap the carried entry into the picked slot, carry the old one on
                lfsr_next = lfsr_adv;
                ram_we    = 1'b1;
                ram_waddr = cur_reg;
                ram_wdata = set_slot(row_reg, pick, key_reg & smask, 1'b1);
                fp_next   = kick_fp;
                key_next  = kick_fp >> cfg.level;
                from_next = cur_reg;
                cur_next  = cur_reg ^ kick_fp[BUCKET_W-1:0];
                kick_next = kick_reg + 1'b1;
            end
            BK_KRD: begin
                ram_re    = 1'b1;
                ram_raddr = cur_reg;
            end
            BK_KEV: begin
                if (freek_ok) begin
                    status_next = ST_STORED;
                    ram_we      = 1'b1;
                    ram_waddr   = cur_reg;
                    ram_wdata   = set_slot(ram_rdata, freek_idx, key_reg & smask, 1'b1);
                    count_next  = count_reg + 1'b1;
                end else if (kick_reg == KW'(KICK_LIMIT)) begin
                    status_next    = ST_EVICTED;
                    accepting_next = 1'b0;
                    vfp_next       = fp_reg;
                    vidx_next      = from_reg;
                end else begin
                    row_next = ram_rdata;
                end
            end
            BK_DONE: begin
                if (out_free) begin
                    mv_next    = 1'b1;
                    mdata_next = {6'd0, count_reg, vidx_reg, vfp_reg, status_reg};
                    mfull_next = (count_reg >= cfg.cap) || !accepting_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_CLEAR;
            clr_reg       <= '0;
            count_reg     <= '0;
            accepting_reg <= 1'b1;
            lfsr_reg      <= LFSR_SEED;
            mv_reg        <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            count_reg     <= count_next;
            accepting_reg <= accepting_next;
            lfsr_reg      <= lfsr_next;
            mv_reg        <= mv_next;
        end
        item_reg   <= item_next;
        row1_reg   <= row1_next;
        row_reg    <= row_next;
        cur_reg    <= cur_next;
        from_reg   <= from_next;
        fp_reg     <= fp_next;
        key_reg    <= key_next;
        kick_reg   <= kick_next;
        status_reg <= status_next;
        vfp_reg    <= vfp_next;
        vidx_reg   <= vidx_next;
        mdata_reg  <= mdata_next;
        mfull_reg  <= mfull_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = mfull_reg;

endmodule

// ===== rtl/cuckoo_filter_engine_unit.sv =====
// Cuckoo filter engine, top level: 1024 buckets of four fingerprint slots.
// Lookup, remove and victim insert pass through the queue, the idle pop, two bucket reads through
// the single RAM read port, evaluate and the done hand-off (which waits for a free output register)
// before m_tvalid rises; an insert that kicks adds a kick, a read and an evaluation per kick round,
// up to KICK_LIMIT rounds. The back end takes no new item until it has handed off the last one.
// Reset: synchronous, active low; afterwards a sweep clears all 1024 buckets of the bucket RAM,
// during which s_tready stays low (configuration writes are still taken).
module cuckoo_filter_engine_unit
    import cfe_pkg::*;
#(
    parameter int KICK_LIMIT = KICK_LIMIT_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // item_hash[63:0], given_fp[94:64], victim_bucket[104:95], zero pad
    input  logic [111:0] s_tdata,
    // mode[1:0], use_given[2]
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[3:0], victim_fingerprint[34:4], victim_index[44:35], occupancy[57:45], pad
    output logic [63:0]  m_tdata,
    // full_res[0]
    output logic [0:0]   m_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [12:0]  cfg_data
);

    cfg_t  cfg_reg, cfg_next;
    item_t front_item, queue_item;
    logic  push, pop, q_full, q_empty, clearing;

    // Configuration registers: take any write at once; out-of-list indexes drop.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_FP_BITS: cfg_next.fp_bits = cfg_data[4:0];
                CFG_LEVEL:   cfg_next.level   = cfg_data[4:0];
                CFG_CAP:     cfg_next.cap     = cfg_data;
                default:     cfg_next         = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.fp_bits <= FP_BITS_RST;
            cfg_reg.level   <= LEVEL_RST;
            cfg_reg.cap     <= CAP_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg_ready = 1'b1;

    // Front end: classify the item and derive fingerprint, key and buckets.
    cfe_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cfg      (cfg_reg),
        .clearing (clearing),
        .q_full   (q_full),
        .push     (push),
        .item     (front_item)
    );

    // Decouple the front end from the table engine.
    cfe_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .item_in  (front_item),
        .full     (q_full),
        .pop      (pop),
        .item_out (queue_item),
        .empty    (q_empty)
    );

    // Table engine with the bucket RAM and the output register.
    cfe_back #(
        .KICK_LIMIT (KICK_LIMIT)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_empty  (q_empty),
        .q_item   (queue_item),
        .q_pop    (pop),
        .clearing (clearing),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
